// ===== hdl/ecgqrs_pkg.sv =====
// Shared types, constants and coefficient lookup for the QRS energy front end.
`timescale 1ns / 1ps
`default_nettype none

package ecgqrs_pkg;

   // Default sizes of the block.
   localparam int TAPS_DEF        = 7;
   localparam int WINDOW_DEF      = 24;
   localparam int SAMPLE_BITS_DEF = 16;

   // Fixed formats.
   localparam int COEF_W    = 16;
   localparam int COEF_FRAC = 15;
   localparam int ENERGY_W  = 35;
   localparam int HALF_LEN  = 4;
   localparam int HALF_LAST = HALF_LEN - 1;

   // Half of each symmetric filter, from the outer taps to the center, in Q1.15.
   localparam logic signed [COEF_W-1:0] SMOOTH_HALF [HALF_LEN] = '{
      16'sd4257, 16'sd4674, 16'sd4938, 16'sd5029
   };
   localparam logic signed [COEF_W-1:0] HIGHPASS_HALF [HALF_LEN] = '{
      -16'sd825, -16'sd860, -16'sd881, 16'sd31075
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SMUL,
      ST_SADD,
      ST_SPUSH,
      ST_HMUL,
      ST_HADD,
      ST_HRND,
      ST_SQ,
      ST_UPD
   } state_type;

   // Operand source of the shared multiplier.
   typedef enum logic [1:0] {
      SRC_SMOOTH,
      SRC_HP,
      SRC_SQ
   } src_type;

   typedef struct packed {
      src_type mul_src;
      logic    mul_en;
      logic    acc_clr;
      logic    push_smooth;
      logic    push_hp;
      logic    load_h;
      logic    update;
   } ctl_type;

   // Coefficient of tap idx; taps further than three from the center are zero.
   function automatic logic signed [COEF_W-1:0] coef_at(input logic hp, input int idx,
                                                        input int center);
      int d;
      logic signed [COEF_W-1:0] c;
      d = idx - center;
      if (d < 0) begin
         d = -d;
      end
      if (d > HALF_LAST) begin
         c = '0;
      end else if (hp) begin
         c = HIGHPASS_HALF[HALF_LAST - d];
      end else begin
         c = SMOOTH_HALF[HALF_LAST - d];
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ecgqrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ecgqrs_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 24
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/ecgqrs_mac.sv =====
// Shared multiplier with product register, accumulator and round-and-saturate.
`timescale 1ns / 1ps
`default_nettype none

module ecgqrs_mac
   import ecgqrs_pkg::*;
#(
   parameter int A_W   = 16,
   parameter int B_W   = 16,
   parameter int ACC_W = 35
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     mul_en,
   input  wire logic                     acc_clr,
   input  wire logic signed [A_W-1:0]    op_a,
   input  wire logic signed [B_W-1:0]    op_b,
   output logic signed      [A_W+B_W-1:0] prod,
   output logic signed      [A_W-1:0]    rnd
);

   localparam int P_W = A_W + B_W;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (A_W - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));

   logic signed [P_W-1:0]   prod_ff;
   logic signed [P_W-1:0]   prod_in;
   logic                    add_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] biased;
   logic signed [ACC_W-1:0] quot;

   assign prod_in = op_a * op_b;

   always_comb begin
      if (acc_clr) begin
         acc_in = '0;
      end else if (add_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         add_ff <= 1'b0;
      end else begin
         add_ff <= mul_en;
      end
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   // Round to nearest with ties upward, then clamp to the sample range.
   always_comb begin
      biased = acc_ff + ROUND_BIAS;
      quot   = biased >>> COEF_FRAC;
      if (quot > SAT_HI) begin
         rnd = SAT_HI[A_W-1:0];
      end else if (quot < SAT_LO) begin
         rnd = SAT_LO[A_W-1:0];
      end else begin
         rnd = quot[A_W-1:0];
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== hdl/ecgqrs_ctrl.sv =====
// Sequencer that steps the shared multiplier through both filters and the square.
`timescale 1ns / 1ps
`default_nettype none

module ecgqrs_ctrl
   import ecgqrs_pkg::*;
#(
   parameter int TAPS = TAPS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    out_free,
   output logic                         req_ready,
   output logic [$clog2(TAPS)-1:0]      tap_idx,
   output ctl_type                      ctl
);

   localparam int TAP_W = $clog2(TAPS);

   state_type          state_ff;
   state_type          state_in;
   logic [TAP_W-1:0]   tap_ff;
   logic [TAP_W-1:0]   tap_in;
   logic               tap_last;

   assign tap_last = (tap_ff == TAP_W'(TAPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_SMUL;
         ST_SMUL:  if (tap_last) state_in = ST_SADD;
         ST_SADD:  state_in = ST_SPUSH;
         ST_SPUSH: state_in = ST_HMUL;
         ST_HMUL:  if (tap_last) state_in = ST_HADD;
         ST_HADD:  state_in = ST_HRND;
         ST_HRND:  state_in = ST_SQ;
         ST_SQ:    state_in = ST_UPD;
         ST_UPD:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl         = '0;
      ctl.mul_src = SRC_SMOOTH;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            ctl.push_smooth = req_valid;
            ctl.acc_clr     = req_valid;
         end
         ST_SMUL: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_src = SRC_SMOOTH;
         end
         ST_SPUSH: begin
            ctl.push_hp = 1'b1;
            ctl.acc_clr = 1'b1;
         end
         ST_HMUL: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_src = SRC_HP;
         end
         ST_HRND: ctl.load_h = 1'b1;
         ST_SQ: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_src = SRC_SQ;
         end
         ST_UPD:  ctl.update = out_free;
         default: ctl = '0;
      endcase
   end

   always_comb begin
      if ((state_ff == ST_SMUL || state_ff == ST_HMUL) && !tap_last) begin
         tap_in = tap_ff + TAP_W'(1);
      end else begin
         tap_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

   assign tap_idx = tap_ff;

endmodule

`default_nettype wire

// ===== hdl/ecg_qrs_energy_front_end.sv =====
// Top level of the QRS energy front end: tap lines, energy window and result register.
`timescale 1ns / 1ps
`default_nettype none

// Usage. Samples arrive on the req_ channel (req_valid, req_ready, req_sample) and one
// result per sample leaves on the rsp_ channel (rsp_valid, rsp_ready, rsp_energy,
// rsp_primed); a transfer happens on an edge where valid and ready are both high.
// Each sample is smoothed, high-pass filtered, squared, and the last WINDOW squares
// are summed into rsp_energy. rsp_primed rises from sample 2*TAPS+WINDOW-2 onward.
// All products go through one shared multiplier: TAPS products per filter plus one
// square, each followed by a registered accumulate. An item therefore runs through
// both filters, the square and the window update before the next input transfer,
// and its result is loaded into the output register at the window update.
// req_ready is high only while the sequencer is idle. The result sits in an output
// register, so a new sample may be taken while the last result waits; if the
// receiver still holds off when the next result is finished, the sequencer waits
// in its final step and req_ready stays low until the result register is free.
// A synchronous reset clears the filter tap lines, the running sum, the fill count
// and the window pointer; the square window needs no clearing pass because entries
// older than the fill count are read as zero.
module ecg_qrs_energy_front_end
   import ecgqrs_pkg::*;
#(
   parameter int TAPS        = TAPS_DEF,
   parameter int WINDOW      = WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic             [ENERGY_W-1:0]    rsp_energy,
   output logic                               rsp_primed
);

   localparam int SB     = SAMPLE_BITS;
   localparam int MB     = (SAMPLE_BITS > COEF_W) ? SAMPLE_BITS : COEF_W;
   localparam int TAP_W  = $clog2(TAPS);
   localparam int ACC_W  = SB + MB + TAP_W;
   localparam int SQ_W   = 2 * SB - 1;
   localparam int PTR_W  = $clog2(WINDOW);
   localparam int PRIME  = 2 * TAPS + WINDOW - 2;
   localparam int FILL_W = $clog2(PRIME + 1);
   localparam int CENTER = TAPS / 2;

   ctl_type                 ctl;
   logic [TAP_W-1:0]        tap_idx;
   logic                    out_free;

   logic signed [SB-1:0]    smooth_ff [TAPS];
   logic signed [SB-1:0]    hp_ff [TAPS];
   logic signed [SB-1:0]    h_ff;

   logic signed [SB-1:0]    op_a;
   logic signed [MB-1:0]    op_b;
   logic signed [SB+MB-1:0] mac_prod;
   logic signed [SB-1:0]    mac_rnd;

   logic [SQ_W-1:0]         sq_w;
   logic [SQ_W-1:0]         old_w;
   logic [ENERGY_W-1:0]     old_e;
   logic [ENERGY_W-1:0]     sum_ff;
   logic [ENERGY_W-1:0]     sum_in;
   logic [PTR_W-1:0]        ptr_ff;
   logic [PTR_W-1:0]        ptr_in;
   logic [FILL_W-1:0]       fill_ff;
   logic [FILL_W-1:0]       fill_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [ENERGY_W-1:0]     rsp_energy_ff;
   logic                    rsp_primed_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   ecgqrs_ctrl #(
      .TAPS (TAPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_ready (req_ready),
      .tap_idx   (tap_idx),
      .ctl       (ctl)
   );

   // Operand selection for the shared multiplier.
   always_comb begin
      case (ctl.mul_src)
         SRC_SMOOTH: begin
            op_a = smooth_ff[tap_idx];
            op_b = MB'(coef_at(1'b0, int'(tap_idx), CENTER));
         end
         SRC_HP: begin
            op_a = hp_ff[tap_idx];
            op_b = MB'(coef_at(1'b1, int'(tap_idx), CENTER));
         end
         SRC_SQ: begin
            op_a = h_ff;
            op_b = MB'(h_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   ecgqrs_mac #(
      .A_W   (SB),
      .B_W   (MB),
      .ACC_W (ACC_W)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .mul_en  (ctl.mul_en),
      .acc_clr (ctl.acc_clr),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod    (mac_prod),
      .rnd     (mac_rnd)
   );

   // Tap lines: the newest value enters at index zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            smooth_ff[i] <= '0;
            hp_ff[i]     <= '0;
         end
      end else begin
         if (ctl.push_smooth) begin
            smooth_ff[0] <= req_sample;
            for (int i = 1; i < TAPS; i++) begin
               smooth_ff[i] <= smooth_ff[i-1];
            end
         end
         if (ctl.push_hp) begin
            hp_ff[0] <= mac_rnd;
            for (int i = 1; i < TAPS; i++) begin
               hp_ff[i] <= hp_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_h) begin
         h_ff <= mac_rnd;
      end
   end

   // Circular square window; ptr_ff points at the oldest square.
   assign sq_w = mac_prod[SQ_W-1:0];

   ecgqrs_ram #(
      .WIDTH (SQ_W),
      .DEPTH (WINDOW)
   ) u_window (
      .clock   (clock),
      .wr_en   (ctl.update),
      .wr_addr (ptr_ff),
      .wr_data (sq_w),
      .rd_addr (ptr_ff),
      .rd_data (old_w)
   );

   // Entries not yet written since reset count as zero.
   assign old_e  = (fill_ff >= FILL_W'(WINDOW)) ? ENERGY_W'(old_w) : '0;
   assign sum_in = sum_ff - old_e + ENERGY_W'(sq_w);
   assign ptr_in = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + PTR_W'(1);
   assign fill_in = (fill_ff == FILL_W'(PRIME)) ? fill_ff : fill_ff + FILL_W'(1);

   always_comb begin
      if (ctl.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctl.update) begin
            sum_ff  <= sum_in;
            ptr_ff  <= ptr_in;
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.update) begin
         rsp_energy_ff <= sum_in;
         rsp_primed_ff <= (fill_in == FILL_W'(PRIME));
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_energy = rsp_energy_ff;
   assign rsp_primed = rsp_primed_ff;

`ifndef SYNTHESIS
   // A result is loaded only into a free output register.
   a_update_free: assert property (@(posedge clock) disable iff (reset)
      ctl.update |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

   // After an input transfer the sequencer is busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken again right after a transfer");

   // The window pointer never leaves the window.
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(WINDOW - 1))
      else $error("window pointer out of range");

   // Once primed, the fill count stays saturated.
   a_fill_hold: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == FILL_W'(PRIME)) |=> (fill_ff == FILL_W'(PRIME)))
      else $error("fill count left saturation");
`endif

endmodule

`default_nettype wire
